// File: rtl/erm1d_pkg.sv
// ----------------------------------------------------------------------------
// erm1d_pkg
// Shared constants, codes, types and the divider step for the 1-D
// elastoplastic return-map pipeline.
// ----------------------------------------------------------------------------
package erm1d_pkg;

   // number formats
   localparam int STRAIN_FRAC_BITS = 30;          // Q1.30 strain
   localparam int STRESS_WIDTH     = 40;          // signed stress, 8 fraction bits
   localparam int STRAIN_W         = 32;
   localparam int ACC_W            = 31;
   localparam int MOD_W            = 39;          // moduli and yield stress
   localparam int ERR_W            = 3;
   localparam int CSR_IDX_W        = 2;

   // internal widths
   localparam int DS_W     = STRAIN_W + 1;        // strain increment magnitude
   localparam int INC_W    = 43;                  // rounded E*|ds|
   localparam int HMUL_W   = 41;                  // rounded H*acc
   localparam int TRIAL_W  = 44;                  // signed trial stress
   localparam int CY_W     = 42;                  // current yield stress
   localparam int F_W      = 42;                  // positive yield excess
   localparam int DG_W     = 63;                  // clamped plastic increment
   localparam int BSUM_W   = 102;                 // E*dg plus rounding
   localparam int BACK_W   = BSUM_W - STRAIN_FRAC_BITS;

   // long division: 78-bit dividend, 40-bit divisor, two bits per stage
   localparam int DIV_NUM_W  = 2 * MOD_W;
   localparam int DIV_DEN_W  = MOD_W + 1;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = DIV_NUM_W / DIV_STEPS;

   // stream packing
   localparam int REQ_W = 168;
   localparam int RSP_W = 144;

   // material models
   localparam logic [1:0] MODEL_ELASTIC   = 2'd0;
   localparam logic [1:0] MODEL_IDEAL     = 2'd1;
   localparam logic [1:0] MODEL_HARDENING = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODEL     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YOUNG     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_YIELD     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HARDENING = 2'd3;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK          = 3'd0;
   localparam logic [ERR_W-1:0] ERR_MODULUS     = 3'd1;
   localparam logic [ERR_W-1:0] ERR_YIELD       = 3'd2;
   localparam logic [ERR_W-1:0] ERR_IDEAL_HARD  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_HARD_ZERO   = 3'd4;
   localparam logic [ERR_W-1:0] ERR_INIT_STRESS = 3'd5;

   // restoring divider state: partial remainder and dividend/quotient shifter
   typedef struct packed {
      logic [DIV_DEN_W-1:0] rem;
      logic [DIV_NUM_W-1:0] num;
   } div_state_type;

   // per-item values that ride along the divider stages
   typedef struct packed {
      logic signed [TRIAL_W-1:0]  trial;
      logic signed [STRAIN_W-1:0] pl;
      logic [ACC_W-1:0]           acc;
      logic                       yld;
      logic [ERR_W-1:0]           err;
   } side_type;

   // one restoring step: quotient bit shifts into the low end of num
   function automatic div_state_type div_step(div_state_type s,
                                              logic [DIV_DEN_W-1:0] den);
      logic [DIV_DEN_W:0] t;
      logic [DIV_DEN_W:0] d;
      div_state_type      r;
      t     = {s.rem, s.num[DIV_NUM_W-1]};
      d     = {1'b0, den};
      r.num = {s.num[DIV_NUM_W-2:0], 1'b0};
      if (t >= d) begin
         r.rem    = DIV_DEN_W'(t - d);
         r.num[0] = 1'b1;
      end else begin
         r.rem = t[DIV_DEN_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/elastoplastic_return_map_1d.sv
// ----------------------------------------------------------------------------
// elastoplastic_return_map_1d
// 1-D return mapping with linear isotropic hardening, one integration point
// per request, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one integration point (new/old strain, old stress, old
//    plastic strain, old accumulated plastic strain); rsp_* returns updated
//    stress, tangent stiffness, plastic strains, and the error code in tuser.
//  - csr_* writes material_model, E, Y, H by index; always ready. Write only
//    while no request is in flight.
//  - Throughput: one request per cycle while the skid buffer has room. The
//    pipeline depth comes from the 78-step long division for the plastic
//    increment, two quotient bits per stage (39 stages), plus five front
//    stages (strain delta, partial products, rounding, trial stress, yield
//    check) and three back stages (clamp, E*dg, sum).
//  - The tangent E*H/(E+H) depends on configuration only and comes from a
//    free-running copy of the divider, which settles after a write ahead of
//    any request accepted after that write.
//  - A 2-entry output skid buffer holds results. The pipeline advances while
//    it has room, so requests are accepted while a result waits; req_tready
//    drops only once both entries are full.
//  - Reset (synchronous, active high) empties the pipeline and skid buffer
//    and sets model 0, E 1, Y 1, H 0.
// ----------------------------------------------------------------------------
module elastoplastic_return_map_1d
   import erm1d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request: [31:0] total_strain, [63:32] old_strain, [103:64] old_stress,
   //          [135:104] old_plastic_strain, [166:136] old_accumulated_plastic
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,
   // response: [39:0] new_stress, [78:40] tangent_stiffness,
   //           [110:79] new_plastic_strain, [141:111] new_accumulated_plastic
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,
   // response tuser: [2:0] error_code
   output logic [ERR_W-1:0]     rsp_tuser,
   // configuration write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MOD_W-1:0]     csr_data
);

   localparam logic [1:0] SKID_FULL = 2'd2;
   localparam logic [DIV_NUM_W-1:0] DG_LIM = DIV_NUM_W'(1) << 62;
   localparam logic [72:0] INC_RND = 73'(1) << (STRAIN_FRAC_BITS - 1);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [1:0]       model_ff;
   logic [MOD_W-1:0] young_ff, yield_ff, hard_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         model_ff <= MODEL_ELASTIC;
         young_ff <= MOD_W'(1);
         yield_ff <= MOD_W'(1);
         hard_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODEL:     model_ff <= csr_data[1:0];
            CSR_YOUNG:     young_ff <= csr_data;
            CSR_YIELD:     yield_ff <= csr_data;
            CSR_HARDENING: hard_ff  <= csr_data;
         endcase
      end
   end

   logic                 plastic;
   logic [DIV_DEN_W-1:0] den;
   logic [31:0]          e_lo, h_lo;
   logic [6:0]           e_hi, h_hi;

   assign plastic = (model_ff == MODEL_IDEAL) || (model_ff == MODEL_HARDENING);
   assign den     = {1'b0, young_ff} + {1'b0, hard_ff};
   assign e_lo    = young_ff[31:0];
   assign e_hi    = young_ff[MOD_W-1:32];
   assign h_lo    = hard_ff[31:0];
   assign h_hi    = hard_ff[MOD_W-1:32];

   // global advance: the skid buffer has room
   logic [1:0] cnt_ff, cnt_in;
   logic       adv;
   assign adv        = (cnt_ff != SKID_FULL);
   assign req_tready = adv;

   // ---------------------------------------------------------------------
   // S1: strain increment and error checks
   // ---------------------------------------------------------------------
   logic signed [STRAIN_W-1:0]     in_eps, in_eps_old, in_pl;
   logic signed [STRESS_WIDTH-1:0] in_sig;
   logic [ACC_W-1:0]               in_acc;
   logic signed [DS_W-1:0]         ds;
   logic [DS_W-1:0]                ds_mag;
   logic [STRESS_WIDTH-1:0]        sig_mag;
   logic [ERR_W-1:0]               err_in;

   assign in_eps     = req_tdata[31:0];
   assign in_eps_old = req_tdata[63:32];
   assign in_sig     = req_tdata[103:64];
   assign in_pl      = req_tdata[135:104];
   assign in_acc     = req_tdata[166:136];

   always_comb begin
      ds      = {in_eps[STRAIN_W-1], in_eps} - {in_eps_old[STRAIN_W-1], in_eps_old};
      ds_mag  = ds[DS_W-1] ? (~ds + DS_W'(1)) : ds;
      sig_mag = in_sig[STRESS_WIDTH-1] ? (~in_sig + STRESS_WIDTH'(1)) : in_sig;
      err_in  = ERR_OK;
      if (young_ff == '0) begin
         err_in = ERR_MODULUS;
      end else if (plastic) begin
         if (yield_ff == '0)
            err_in = ERR_YIELD;
         else if (model_ff == MODEL_IDEAL && hard_ff != '0)
            err_in = ERR_IDEAL_HARD;
         else if (model_ff == MODEL_HARDENING && hard_ff == '0)
            err_in = ERR_HARD_ZERO;
         else if (in_eps_old == '0 && in_pl == '0 && in_acc == '0 &&
                  sig_mag > {1'b0, yield_ff})
            err_in = ERR_INIT_STRESS;
      end
   end

   logic                           s1_vld_ff;
   logic [DS_W-1:0]                s1_dsmag_ff;
   logic                           s1_neg_ff;
   logic signed [STRESS_WIDTH-1:0] s1_sig_ff;
   logic signed [STRAIN_W-1:0]     s1_pl_ff;
   logic [ACC_W-1:0]               s1_acc_ff;
   logic [ERR_W-1:0]               s1_err_ff;

   // ---------------------------------------------------------------------
   // S2: partial products of E*|ds| and H*acc
   // ---------------------------------------------------------------------
   logic                           s2_vld_ff;
   logic [63:0]                    s2_pll_ff;
   logic [38:0]                    s2_phl_ff;
   logic [31:0]                    s2_plh_ff;
   logic [6:0]                     s2_phh_ff;
   logic [62:0]                    s2_hpl_ff;
   logic [37:0]                    s2_hph_ff;
   logic                           s2_neg_ff;
   logic signed [STRESS_WIDTH-1:0] s2_sig_ff;
   logic signed [STRAIN_W-1:0]     s2_pl_ff;
   logic [ACC_W-1:0]               s2_acc_ff;
   logic [ERR_W-1:0]               s2_err_ff;

   // ---------------------------------------------------------------------
   // S3: sum and round the two products
   // ---------------------------------------------------------------------
   logic [72:0] inc_sum;
   logic [70:0] hmul_sum;

   assign inc_sum  = 73'(s2_pll_ff) + 73'({s2_phl_ff, 32'd0}) +
                     73'({s2_plh_ff, 32'd0}) + 73'({s2_phh_ff, 64'd0}) + INC_RND;
   assign hmul_sum = 71'(s2_hpl_ff) + 71'({s2_hph_ff, 32'd0}) + 71'(INC_RND);

   logic                           s3_vld_ff;
   logic [INC_W-1:0]               s3_inc_ff;
   logic [HMUL_W-1:0]              s3_hmul_ff;
   logic                           s3_neg_ff;
   logic signed [STRESS_WIDTH-1:0] s3_sig_ff;
   logic signed [STRAIN_W-1:0]     s3_pl_ff;
   logic [ACC_W-1:0]               s3_acc_ff;
   logic [ERR_W-1:0]               s3_err_ff;

   // ---------------------------------------------------------------------
   // S4: trial stress and current yield stress
   // ---------------------------------------------------------------------
   logic signed [TRIAL_W-1:0] trial_in, sig_ext, inc_ext;
   logic [CY_W-1:0]           cy_in;

   assign sig_ext  = {{(TRIAL_W-STRESS_WIDTH){s3_sig_ff[STRESS_WIDTH-1]}}, s3_sig_ff};
   assign inc_ext  = {1'b0, s3_inc_ff};
   assign trial_in = s3_neg_ff ? (sig_ext - inc_ext) : (sig_ext + inc_ext);
   assign cy_in    = {3'b0, yield_ff} + {1'b0, s3_hmul_ff};

   logic                       s4_vld_ff;
   logic signed [TRIAL_W-1:0]  s4_trial_ff;
   logic [CY_W-1:0]            s4_cy_ff;
   logic signed [STRAIN_W-1:0] s4_pl_ff;
   logic [ACC_W-1:0]           s4_acc_ff;
   logic [ERR_W-1:0]           s4_err_ff;

   // ---------------------------------------------------------------------
   // S5: yield function
   // ---------------------------------------------------------------------
   logic [TRIAL_W-1:0]  trial_mag;
   logic [TRIAL_W:0]    f_full;
   logic                yld_in;

   assign trial_mag = s4_trial_ff[TRIAL_W-1] ? (~s4_trial_ff + TRIAL_W'(1)) : s4_trial_ff;
   assign f_full    = {1'b0, trial_mag} - {3'b0, s4_cy_ff};
   assign yld_in    = plastic && !f_full[TRIAL_W] && (f_full != '0);

   logic       s5_vld_ff;
   logic [F_W-1:0] s5_f_ff;
   side_type   s5_side_ff;

   // ---------------------------------------------------------------------
   // D1..D39: dg = floor(f * 2^30 / (E+H)), two quotient bits per stage
   // ---------------------------------------------------------------------
   logic          dv_vld_ff  [DIV_STAGES];
   div_state_type dv_st_ff   [DIV_STAGES];
   div_state_type dv_st_in   [DIV_STAGES];
   side_type      dv_side_ff [DIV_STAGES];
   div_state_type dv_entry;

   assign dv_entry.rem = '0;
   assign dv_entry.num = DIV_NUM_W'({s5_f_ff, {STRAIN_FRAC_BITS{1'b0}}});

   always_comb begin
      div_state_type cur;
      for (int s = 0; s < DIV_STAGES; s++) begin
         cur = (s == 0) ? dv_entry : dv_st_ff[s-1];
         for (int k = 0; k < DIV_STEPS; k++)
            cur = div_step(cur, den);
         dv_st_in[s] = cur;
      end
   end

   // free-running divider for tangent E*H/(E+H)
   logic [63:0]   sp_ll_ff;
   logic [38:0]   sp_lh_ff, sp_hl_ff;
   logic [13:0]   sp_hh_ff;
   logic [DIV_NUM_W-1:0] sp_prod_ff;
   div_state_type sd_st_ff [DIV_STAGES];
   div_state_type sd_st_in [DIV_STAGES];
   div_state_type sd_entry;

   assign sd_entry.rem = '0;
   assign sd_entry.num = sp_prod_ff;

   always_comb begin
      div_state_type cur;
      for (int s = 0; s < DIV_STAGES; s++) begin
         cur = (s == 0) ? sd_entry : sd_st_ff[s-1];
         for (int k = 0; k < DIV_STEPS; k++)
            cur = div_step(cur, den);
         sd_st_in[s] = cur;
      end
   end

   always_ff @(posedge clock) begin
      sp_ll_ff   <= e_lo * h_lo;
      sp_lh_ff   <= e_lo * h_hi;
      sp_hl_ff   <= e_hi * h_lo;
      sp_hh_ff   <= e_hi * h_hi;
      sp_prod_ff <= DIV_NUM_W'(sp_ll_ff) + DIV_NUM_W'({sp_lh_ff, 32'd0}) +
                    DIV_NUM_W'({sp_hl_ff, 32'd0}) + DIV_NUM_W'({sp_hh_ff, 64'd0});
      for (int s = 0; s < DIV_STAGES; s++)
         sd_st_ff[s] <= sd_st_in[s];
   end

   // ---------------------------------------------------------------------
   // Q1: clamp dg;  Q2: E*dg partial products;  Q3: sum and round
   // ---------------------------------------------------------------------
   logic [DIV_NUM_W-1:0] q_full;
   logic [DG_W-1:0]      dg_in;

   assign q_full = dv_st_ff[DIV_STAGES-1].num;
   assign dg_in  = (q_full > DG_LIM) ? DG_W'(DG_LIM) : q_full[DG_W-1:0];

   logic            q1_vld_ff;
   logic [DG_W-1:0] q1_dg_ff;
   side_type        q1_side_ff;

   logic            q2_vld_ff;
   logic [63:0]     q2_bll_ff;
   logic [62:0]     q2_blh_ff;
   logic [38:0]     q2_bhl_ff;
   logic [37:0]     q2_bhh_ff;
   logic [DG_W-1:0] q2_dg_ff;
   side_type        q2_side_ff;

   logic [BSUM_W-1:0] bsum;
   assign bsum = BSUM_W'(q2_bll_ff) + BSUM_W'({q2_blh_ff, 32'd0}) +
                 BSUM_W'({q2_bhl_ff, 32'd0}) + BSUM_W'({q2_bhh_ff, 64'd0}) +
                 BSUM_W'(INC_RND);

   logic              q3_vld_ff;
   logic [BACK_W-1:0] q3_back_ff;
   logic [DG_W-1:0]   q3_dg_ff;
   side_type          q3_side_ff;

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         for (int s = 0; s < DIV_STAGES; s++)
            dv_vld_ff[s] <= 1'b0;
         q1_vld_ff <= 1'b0;
         q2_vld_ff <= 1'b0;
         q3_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff    <= req_tvalid;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s4_vld_ff    <= s3_vld_ff;
         s5_vld_ff    <= s4_vld_ff;
         dv_vld_ff[0] <= s5_vld_ff;
         for (int s = 1; s < DIV_STAGES; s++)
            dv_vld_ff[s] <= dv_vld_ff[s-1];
         q1_vld_ff <= dv_vld_ff[DIV_STAGES-1];
         q2_vld_ff <= q1_vld_ff;
         q3_vld_ff <= q2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // S1
         s1_dsmag_ff <= ds_mag;
         s1_neg_ff   <= ds[DS_W-1];
         s1_sig_ff   <= in_sig;
         s1_pl_ff    <= in_pl;
         s1_acc_ff   <= in_acc;
         s1_err_ff   <= err_in;
         // S2
         s2_pll_ff <= e_lo * s1_dsmag_ff[31:0];
         s2_phl_ff <= e_hi * s1_dsmag_ff[31:0];
         s2_plh_ff <= s1_dsmag_ff[DS_W-1] ? e_lo : 32'd0;
         s2_phh_ff <= s1_dsmag_ff[DS_W-1] ? e_hi : 7'd0;
         s2_hpl_ff <= h_lo * s1_acc_ff;
         s2_hph_ff <= h_hi * s1_acc_ff;
         s2_neg_ff <= s1_neg_ff;
         s2_sig_ff <= s1_sig_ff;
         s2_pl_ff  <= s1_pl_ff;
         s2_acc_ff <= s1_acc_ff;
         s2_err_ff <= s1_err_ff;
         // S3
         s3_inc_ff  <= inc_sum[72:STRAIN_FRAC_BITS];
         s3_hmul_ff <= hmul_sum[70:STRAIN_FRAC_BITS];
         s3_neg_ff  <= s2_neg_ff;
         s3_sig_ff  <= s2_sig_ff;
         s3_pl_ff   <= s2_pl_ff;
         s3_acc_ff  <= s2_acc_ff;
         s3_err_ff  <= s2_err_ff;
         // S4
         s4_trial_ff <= trial_in;
         s4_cy_ff    <= cy_in;
         s4_pl_ff    <= s3_pl_ff;
         s4_acc_ff   <= s3_acc_ff;
         s4_err_ff   <= s3_err_ff;
         // S5
         s5_f_ff          <= f_full[F_W-1:0];
         s5_side_ff.trial <= s4_trial_ff;
         s5_side_ff.pl    <= s4_pl_ff;
         s5_side_ff.acc   <= s4_acc_ff;
         s5_side_ff.yld   <= yld_in;
         s5_side_ff.err   <= s4_err_ff;
         // divider
         for (int s = 0; s < DIV_STAGES; s++)
            dv_st_ff[s] <= dv_st_in[s];
         dv_side_ff[0] <= s5_side_ff;
         for (int s = 1; s < DIV_STAGES; s++)
            dv_side_ff[s] <= dv_side_ff[s-1];
         // Q1
         q1_dg_ff   <= dg_in;
         q1_side_ff <= dv_side_ff[DIV_STAGES-1];
         // Q2
         q2_bll_ff  <= e_lo * q1_dg_ff[31:0];
         q2_blh_ff  <= e_lo * q1_dg_ff[DG_W-1:32];
         q2_bhl_ff  <= e_hi * q1_dg_ff[31:0];
         q2_bhh_ff  <= e_hi * q1_dg_ff[DG_W-1:32];
         q2_dg_ff   <= q1_dg_ff;
         q2_side_ff <= q1_side_ff;
         // Q3 (back beyond 2^62 saturates the stress the same as the clamp)
         q3_back_ff <= bsum[BSUM_W-1:STRAIN_FRAC_BITS];
         q3_dg_ff   <= q2_dg_ff;
         q3_side_ff <= q2_side_ff;
      end
   end

   // ---------------------------------------------------------------------
   // final update and saturation, straight into the skid buffer
   // ---------------------------------------------------------------------
   logic [BACK_W-1:0]            back_sel;
   logic [DG_W-1:0]              dg_sel;
   logic                         trial_pos;
   logic signed [BACK_W+1:0]     stress_full;
   logic signed [DG_W+1:0]       pl_full;
   logic [63:0]                  acc_full;
   logic [STRESS_WIDTH-1:0]      stress_out;
   logic [STRAIN_W-1:0]          pl_out;
   logic [ACC_W-1:0]             acc_out;
   logic [MOD_W-1:0]             stiff_out;
   logic [RSP_W-1:0]             data_out;
   logic [ERR_W-1:0]             user_out;

   always_comb begin
      back_sel  = q3_side_ff.yld ? q3_back_ff : '0;
      dg_sel    = q3_side_ff.yld ? q3_dg_ff : '0;
      trial_pos = !q3_side_ff.trial[TRIAL_W-1];

      stress_full = trial_pos ?
         ($signed({{(BACK_W+2-TRIAL_W){q3_side_ff.trial[TRIAL_W-1]}}, q3_side_ff.trial})
          - $signed({2'b00, back_sel})) :
         ($signed({{(BACK_W+2-TRIAL_W){q3_side_ff.trial[TRIAL_W-1]}}, q3_side_ff.trial})
          + $signed({2'b00, back_sel}));
      pl_full = trial_pos ?
         ($signed({{(DG_W+2-STRAIN_W){q3_side_ff.pl[STRAIN_W-1]}}, q3_side_ff.pl})
          + $signed({2'b00, dg_sel})) :
         ($signed({{(DG_W+2-STRAIN_W){q3_side_ff.pl[STRAIN_W-1]}}, q3_side_ff.pl})
          - $signed({2'b00, dg_sel}));
      acc_full = 64'(q3_side_ff.acc) + 64'(dg_sel);

      // saturate when the bits above the result do not all match its sign
      if (!stress_full[BACK_W+1] && (|stress_full[BACK_W:STRESS_WIDTH-1]))
         stress_out = {1'b0, {(STRESS_WIDTH-1){1'b1}}};
      else if (stress_full[BACK_W+1] && !(&stress_full[BACK_W:STRESS_WIDTH-1]))
         stress_out = {1'b1, {(STRESS_WIDTH-1){1'b0}}};
      else
         stress_out = stress_full[STRESS_WIDTH-1:0];

      if (!pl_full[DG_W+1] && (|pl_full[DG_W:STRAIN_W-1]))
         pl_out = {1'b0, {(STRAIN_W-1){1'b1}}};
      else if (pl_full[DG_W+1] && !(&pl_full[DG_W:STRAIN_W-1]))
         pl_out = {1'b1, {(STRAIN_W-1){1'b0}}};
      else
         pl_out = pl_full[STRAIN_W-1:0];

      acc_out   = (|acc_full[63:ACC_W]) ? {ACC_W{1'b1}} : acc_full[ACC_W-1:0];
      stiff_out = q3_side_ff.yld ? sd_st_ff[DIV_STAGES-1].num[MOD_W-1:0] : young_ff;

      user_out = q3_side_ff.err;
      if (q3_side_ff.err != ERR_OK)
         data_out = '0;
      else
         data_out = {2'b00, acc_out, pl_out, stiff_out, stress_out};
   end

   // ---------------------------------------------------------------------
   // two-entry output skid buffer
   // ---------------------------------------------------------------------
   logic [RSP_W-1:0] head_data_ff, spare_data_ff;
   logic [ERR_W-1:0] head_user_ff, spare_user_ff;
   logic             push, pop;

   assign push       = adv && q3_vld_ff;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = head_data_ff;
   assign rsp_tuser  = head_user_ff;
   assign cnt_in     = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset)
         cnt_ff <= 2'd0;
      else
         cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (push && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop))) begin
         head_data_ff <= data_out;
         head_user_ff <= user_out;
      end else if (pop && cnt_ff == SKID_FULL) begin
         head_data_ff <= spare_data_ff;
         head_user_ff <= spare_user_ff;
      end
      if (push && cnt_ff == 2'd1 && !pop) begin
         spare_data_ff <= data_out;
         spare_user_ff <= user_out;
      end
   end

`ifndef SYNTHESIS
   a_skid_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("skid count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == SKID_FULL |-> !push)
      else $error("result pushed into full skid buffer");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ERR_OK |-> rsp_tdata == '0)
      else $error("error result carries nonzero data");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");
`endif

endmodule

// File: tb/sv/elastoplastic_return_map_1d_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastoplastic_return_map_1d_tb
// Streams integration points through the return-map pipeline under several
// material settings and compares every response field against a bit-exact
// fixed-point predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module elastoplastic_return_map_1d_tb;
   import erm1d_pkg::*;

   typedef struct packed {
      logic [ACC_W-1:0]               acc;
      logic signed [STRAIN_W-1:0]     pl;
      logic signed [STRESS_WIDTH-1:0] stress;
      logic signed [STRAIN_W-1:0]     old_strain;
      logic signed [STRAIN_W-1:0]     total_strain;
   } point_t;

   typedef struct packed {
      logic signed [STRESS_WIDTH-1:0] stress;
      logic [MOD_W-1:0]               stiff;
      logic signed [STRAIN_W-1:0]     pl;
      logic [ACC_W-1:0]               acc;
      logic [ERR_W-1:0]               err;
   } update_t;

   localparam logic [127:0] LIM      = 128'h1 << 62;
   localparam logic [MOD_W-1:0] MODMAX = {MOD_W{1'b1}};

   // ---------------------------------------------------------------------------
   // scoreboard: material copy, return-map predictor, pending update queue
   // ---------------------------------------------------------------------------
   class return_map_board;
      logic [1:0]       model;
      logic [MOD_W-1:0] e, y, h;
      update_t          pending_q[$];
      int               mismatches, checked, yielded;
      int               err_seen[8];

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [MOD_W-1:0] v);
         case (idx)
            CSR_MODEL:     model = v[1:0];
            CSR_YOUNG:     e = v;
            CSR_YIELD:     y = v;
            CSR_HARDENING: h = v;
            default: ;
         endcase
      endfunction

      // round(a*b / 2^30), clamped to 2^62
      function logic [127:0] round_mul(logic [127:0] a, logic [127:0] b);
         logic [127:0] p;
         p = (a * b + (128'h1 << (STRAIN_FRAC_BITS - 1))) >> STRAIN_FRAC_BITS;
         return p > LIM ? LIM : p;
      endfunction

      function update_t return_map(point_t p);
         update_t      u;
         bit           plastic;
         longint       ds, trial, stress, pl, f, sig_mag;
         logic [127:0] inc, cy, dg, back, stiff, den;
         logic [63:0]  acc;
         logic [2:0]   err;
         plastic = (model == MODEL_IDEAL) || (model == MODEL_HARDENING);
         pl      = p.pl;
         acc     = p.acc;
         sig_mag = p.stress < 0 ? -longint'(p.stress) : longint'(p.stress);
         err     = ERR_OK;
         if (e == 0) err = ERR_MODULUS;
         else if (plastic) begin
            if (y == 0) err = ERR_YIELD;
            else if (model == MODEL_IDEAL && h != 0) err = ERR_IDEAL_HARD;
            else if (model == MODEL_HARDENING && h == 0) err = ERR_HARD_ZERO;
            else if (p.old_strain == 0 && p.pl == 0 && p.acc == 0 && sig_mag > longint'(y))
               err = ERR_INIT_STRESS;
         end
         u = '0;
         u.err = err;
         if (err != ERR_OK) return u;

         ds    = longint'(p.total_strain) - longint'(p.old_strain);
         inc   = round_mul(e, ds < 0 ? -ds : ds);
         trial = p.stress;
         trial = ds < 0 ? trial - longint'(inc[63:0]) : trial + longint'(inc[63:0]);
         if (trial > longint'(LIM[63:0])) trial = LIM[63:0];
         if (trial < -longint'(LIM[63:0])) trial = -longint'(LIM[63:0]);
         stress = trial;
         stiff  = e;
         if (plastic) begin
            cy = 128'(y) + round_mul(h, acc);
            if (cy > LIM) cy = LIM;
            f = (trial < 0 ? -trial : trial) - longint'(cy[63:0]);
            if (f > 0) begin
               yielded++;
               den = 128'(e) + 128'(h);
               dg  = (128'(f) << STRAIN_FRAC_BITS) / den;
               if (dg > LIM) dg = LIM;
               back  = round_mul(e, dg);
               stiff = (128'(e) * 128'(h)) / den;
               if (stiff > LIM) stiff = LIM;
               if (trial >= 0) begin
                  stress = trial - longint'(back[63:0]);
                  pl     = pl + longint'(dg[63:0]);
               end else begin
                  stress = trial + longint'(back[63:0]);
                  pl     = pl - longint'(dg[63:0]);
               end
               acc = acc + dg[63:0];
            end
         end
         if (stress > (64'sd1 <<< 39) - 1) stress = (64'sd1 <<< 39) - 1;
         if (stress < -(64'sd1 <<< 39)) stress = -(64'sd1 <<< 39);
         if (pl > 64'sd2147483647) pl = 64'sd2147483647;
         if (pl < -64'sd2147483648) pl = -64'sd2147483648;
         u.stress = stress[STRESS_WIDTH-1:0];
         u.stiff  = stiff[MOD_W-1:0];
         u.pl     = pl[31:0];
         u.acc    = acc > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : acc[30:0];
         return u;
      endfunction

      function void note_request(point_t p);
         update_t u;
         u = return_map(p);
         err_seen[u.err]++;
         pending_q.push_back(u);
      endfunction

      function void check_response(update_t act);
         update_t exp_u;
         checked++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", act);
            return;
         end
         exp_u = pending_q.pop_front();
         if (act.stress !== exp_u.stress || act.stiff !== exp_u.stiff ||
             act.pl !== exp_u.pl || act.acc !== exp_u.acc || act.err !== exp_u.err) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch #%0d at %0t", mismatches, $realtime);
               $display("  exp stress %0d stiff %0d pl %0d acc %0d err %0d",
                        exp_u.stress, exp_u.stiff, exp_u.pl, exp_u.acc, exp_u.err);
               $display("  act stress %0d stiff %0d pl %0d acc %0d err %0d",
                        act.stress, act.stiff, act.pl, act.acc, act.err);
            end
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // DUT hookup
   // ---------------------------------------------------------------------------
   logic                 clock, reset;
   logic                 req_tvalid, req_tready;
   logic [REQ_W-1:0]     req_tdata;
   logic                 rsp_tvalid, rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;
   logic [ERR_W-1:0]     rsp_tuser;
   logic                 csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [MOD_W-1:0]     csr_data;

   elastoplastic_return_map_1d u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   return_map_board board;
   bit  calm;        // no idling on either side while set
   int  hold_left;   // receiver hold-off, counted down by the receiver
   int  sent;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard limit on run time
   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

   // receiver: random backpressure, plus a long hold-off when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else
            rsp_tready = calm || ($urandom_range(0, 99) >= 30);
      end
   end

   // response monitor
   always @(posedge clock) begin
      update_t a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.stress = rsp_tdata[39:0];
         a.stiff  = rsp_tdata[78:40];
         a.pl     = rsp_tdata[110:79];
         a.acc    = rsp_tdata[141:111];
         a.err    = rsp_tuser;
         board.check_response(a);
      end
   end

   // ---------------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------------
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [MOD_W-1:0] v);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = v;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, v);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_material(logic [1:0] m, logic [MOD_W-1:0] e,
                               logic [MOD_W-1:0] y, logic [MOD_W-1:0] h);
      write_reg(CSR_MODEL, MOD_W'(m));
      write_reg(CSR_YOUNG, e);
      write_reg(CSR_YIELD, y);
      write_reg(CSR_HARDENING, h);
      repeat (50) @(negedge clock);   // tangent divider settles
   endtask

   task automatic send_point(point_t p);
      while (!calm && $urandom_range(0, 99) < 30) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {1'b0, p};
      do @(posedge clock); while (!req_tready);
      board.note_request(p);
      sent++;
      @(negedge clock);
   endtask

   // wait for the pipeline to drain before touching registers
   task automatic drain();
      req_tvalid = 1'b0;
      while (board.pending_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   function automatic point_t random_point();
      point_t p;
      int     kind;
      kind = $urandom_range(0, 99);
      p.total_strain = $urandom;
      p.old_strain   = $urandom;
      p.stress       = STRESS_WIDTH'({$urandom, $urandom});
      p.pl           = $urandom;
      p.acc          = ACC_W'($urandom);
      if (kind >= 15) begin
         // well-formed: moderate history, small strain step
         p.old_strain   = p.old_strain >>> $urandom_range(0, 12);
         p.total_strain = p.old_strain + ($signed($urandom) >>> $urandom_range(4, 31));
         p.stress       = p.stress >>> $urandom_range(0, 39);
         p.pl           = p.pl >>> $urandom_range(0, 31);
         p.acc          = p.acc >> $urandom_range(0, 30);
         if (kind < 30) begin
            // virgin point: initial stress check applies
            p.old_strain = '0;
            p.pl         = '0;
            p.acc        = '0;
         end
      end
      return p;
   endfunction

   task automatic directed_points();
      point_t p;
      p = '0;                                        send_point(p); // all zero
      p.total_strain = 32'h7FFF_FFFF; p.old_strain = 32'h8000_0000;
      p.stress = 40'h7F_FFFF_FFFF; p.pl = 32'h7FFF_FFFF; p.acc = 31'h7FFF_FFFF;
      send_point(p);                                 // field maxima, old strain at its minimum
      p.total_strain = 32'h8000_0000; p.old_strain = 32'h7FFF_FFFF;
      p.stress = 40'h80_0000_0000; p.pl = 32'h8000_0000; p.acc = 31'h7FFF_FFFF;
      send_point(p);                                 // field minima, old strain and acc at their maxima
      p = '0; p.stress = 40'sd256;                   send_point(p); // virgin, small stress
      p = '0; p.stress = -40'sd256;                  send_point(p);
      p = '0; p.stress = 40'(board.y);               send_point(p); // exactly at yield
      p = '0; p.stress = 40'(board.y) + 1;           send_point(p); // just beyond yield
      p = '0; p.stress = -40'(board.y) - 1;          send_point(p);
      p = '0; p.total_strain = 32'sd1 <<< 20;        send_point(p); // tension step
      p = '0; p.total_strain = -(32'sd1 <<< 20);     send_point(p); // compression step
      p = '0; p.old_strain = 32'sd5; p.total_strain = 32'sd5; send_point(p); // zero trial
      p = '0; p.pl = 32'sd1; p.total_strain = 32'h4000_0000; send_point(p);
      p = '0; p.acc = 31'h7FFF_FFFF; p.total_strain = 32'h7FFF_FFFF; send_point(p);
      p = '0; p.pl = 32'h7FFF_FF00; p.acc = 31'h7FFF_FF00; p.old_strain = 32'h8000_0000;
      p.total_strain = 32'h7FFF_FFFF;                send_point(p); // plastic saturation
      p.pl = 32'h8000_0100; p.old_strain = 32'h7FFF_FFFF;
      p.total_strain = 32'h8000_0000;                send_point(p);
      p = '0; p.stress = 40'h7F_FFFF_FFFF; p.acc = 31'd1; send_point(p);
      p = '0; p.stress = 40'h80_0000_0000; p.pl = -32'sd1; send_point(p);
      p = '0; p.old_strain = 32'sd1; p.stress = 40'h55_5555_5555;
      p.total_strain = 32'hAAAA_AAAA;                send_point(p);
   endtask

   task automatic random_points(int n);
      repeat (n) send_point(random_point());
   endtask

   // ---------------------------------------------------------------------------
   // run
   // ---------------------------------------------------------------------------
   initial begin
      int phase;
      board      = new();
      board.set_reg(CSR_MODEL, MODEL_ELASTIC);
      board.set_reg(CSR_YOUNG, 1);
      board.set_reg(CSR_YIELD, 1);
      board.set_reg(CSR_HARDENING, 0);
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_MODEL;
      csr_data   = '0;
      calm       = 1'b0;
      hold_left  = 0;
      sent       = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (50) @(negedge clock);

      // reset material values
      directed_points();
      random_points(160);
      drain();

      for (phase = 0; phase < 16; phase++) begin
         case (phase)
            0:  set_material(MODEL_HARDENING, 39'd200000 << 8, 39'd250 << 8, 39'd2000 << 8);
            1:  set_material(MODEL_IDEAL, 39'd200000 << 8, 39'd250 << 8, 0);
            2:  set_material(MODEL_ELASTIC, 39'd70000 << 8, 39'd100 << 8, 0);
            3:  set_material(MODEL_HARDENING, MODMAX, MODMAX, MODMAX);
            4:  set_material(MODEL_HARDENING, 1, 1, 1);
            5:  set_material(MODEL_IDEAL, MODMAX, 1, 0);
            6:  set_material(MODEL_ELASTIC, 0, 5, 0);               // modulus error
            7:  set_material(MODEL_IDEAL, 1000, 0, 0);              // yield error
            8:  set_material(MODEL_IDEAL, 1000, 10, 5);             // ideal with hardening
            9:  set_material(MODEL_HARDENING, 1000, 10, 0);         // hardening missing
            10: set_material(2'd3, 12345, 10, 7);                   // unused model code
            default:
               set_material(2'($urandom_range(0, 3)),
                            MOD_W'({$urandom, $urandom} >> $urandom_range(25, 63)),
                            MOD_W'({$urandom, $urandom} >> $urandom_range(25, 63)),
                            MOD_W'({$urandom, $urandom} >> $urandom_range(25, 63)));
         endcase
         if (phase == 0) directed_points();
         // long receiver hold-off: pipeline and skid buffer fill up
         if (phase == 1) hold_left = 300;
         calm = (phase == 3);
         random_points(phase < 11 ? 80 : 95);
         calm = 1'b0;
         drain();   // sender pauses until everything is back
      end

      $display("%0d requests, %0d responses, %0d yielded", sent, board.checked,
               board.yielded);
      $display("error codes 0..5: %0d %0d %0d %0d %0d %0d", board.err_seen[0],
               board.err_seen[1], board.err_seen[2], board.err_seen[3],
               board.err_seen[4], board.err_seen[5]);
      $display("%0d mismatches, %0d updates left over", board.mismatches,
               board.pending_q.size());
      if (board.mismatches == 0 && board.pending_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/erm1d_pkg.sv
rtl/elastoplastic_return_map_1d.sv
tb/sv/elastoplastic_return_map_1d_tb.sv
